// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque with positional delete.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int OP_W      = 3;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BEFORE = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AFTER  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value_in;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_out;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       element_count;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic check;
        logic capture;
        logic shift_rd;
        logic shift_wr;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic removal;
        logic del;
        logic more;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer for request decode, store read, shift loop and response.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    output logic          done,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_CAPT  = 3'd2;
    localparam logic [2:0] S_SRD   = 3'd3;
    localparam logic [2:0] S_SWR   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign busy   = !((state_reg == S_IDLE) || (state_reg == S_RESP));
    assign accept = start && !busy;
    assign done   = (state_reg == S_RESP);

    always_comb
    begin
        cmd          = '0;
        cmd.load     = accept;
        cmd.check    = (state_reg == S_CHECK);
        cmd.capture  = (state_reg == S_CAPT);
        cmd.shift_rd = (state_reg == S_SRD) && stat.more;
        cmd.finish   = (state_reg == S_SRD) && !stat.more;
        cmd.shift_wr = (state_reg == S_SWR);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = accept ? S_CHECK : S_IDLE;
            S_CHECK: state_next = stat.removal ? S_CAPT : S_RESP;
            S_CAPT:  state_next = stat.del ? S_SRD : S_RESP;
            S_SRD:   state_next = stat.more ? S_SWR : S_RESP;
            S_SWR:   state_next = S_SRD;
            S_RESP:  state_next = accept ? S_CHECK : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) != S_IDLE))
        else $error("response without preceding work");

    a_swr_after_srd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> $past(cmd.shift_rd))
        else $error("shift write without shift read");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_CHECK))
        else $error("accepted transaction not decoded");

endmodule

`default_nettype wire

// ===== rtl/core/bdq_dp.sv =====
// ----------------------------------------------------------------------------
// bdq_dp
// Circular word store, head and count registers, request decode and result.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_dp
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire req_t    request,
    input  wire dp_cmd_t cmd,
    output dp_stat_t     stat,
    output rsp_t         result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                               input logic [CW-1:0] x);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(x);
        if (s >= (CW+1)'(DEPTH))
            s = s - (CW+1)'(DEPTH);
        return s[IW-1:0];
    endfunction

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    req_t                     req_reg;
    logic [IW-1:0]            head_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            cursor_reg;
    logic                     del_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic [STATUS_W-1:0]      status_reg;

    logic [EW-1:0]            pos_e;
    logic [EW-1:0]            cnt_e;
    logic [STATUS_W-1:0]      chk_status;
    logic [CW-1:0]            rem_k;
    logic                     do_push_f;
    logic                     do_push_b;
    logic                     do_pop_f;
    logic                     do_pop_b;
    logic                     do_del;
    logic [IW-1:0]            head_dec;
    logic [IW-1:0]            head_inc;
    logic [CW-1:0]            cursor_inc;
    logic [IW-1:0]            raddr;
    logic [IW-1:0]            waddr;
    logic signed [WORD_W-1:0] wdata;
    logic                     we;

    always_comb
    begin
        pos_e      = EW'(req_reg.position);
        cnt_e      = EW'(count_reg);
        chk_status = ST_OK;
        rem_k      = '0;
        do_push_f  = 1'b0;
        do_push_b  = 1'b0;
        do_pop_f   = 1'b0;
        do_pop_b   = 1'b0;
        do_del     = 1'b0;
        case (req_reg.op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (count_reg == CW'(DEPTH))
                    chk_status = ST_FULL;
                else if (req_reg.op == OP_PUSH_FRONT)
                    do_push_f = 1'b1;
                else
                    do_push_b = 1'b1;
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (count_reg == '0)
                    chk_status = ST_EMPTY;
                else if (req_reg.op == OP_POP_FRONT)
                    do_pop_f = 1'b1;
                else
                begin
                    do_pop_b = 1'b1;
                    rem_k    = count_reg - CW'(1);
                end
            end
            OP_DEL_BEFORE:
            begin
                if (count_reg == '0)
                    chk_status = ST_EMPTY;
                else if ((pos_e < EW'(2)) || (pos_e > cnt_e + EW'(1)))
                    chk_status = ST_BADPOS;
                else
                begin
                    do_del = 1'b1;
                    rem_k  = CW'(pos_e - EW'(2));
                end
            end
            OP_DEL_AFTER:
            begin
                if (count_reg == '0)
                    chk_status = ST_EMPTY;
                else if ((pos_e == '0) || (pos_e >= cnt_e))
                    chk_status = ST_BADPOS;
                else
                begin
                    do_del = 1'b1;
                    rem_k  = CW'(pos_e);
                end
            end
            default:
            begin
                chk_status = ST_OK;
            end
        endcase
    end

    assign head_dec   = (head_reg == '0) ? IW'(DEPTH - 1) : head_reg - IW'(1);
    assign head_inc   = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);
    assign cursor_inc = cursor_reg + CW'(1);

    assign stat.removal = do_pop_f || do_pop_b || do_del;
    assign stat.del     = del_reg;
    assign stat.more    = ((CW+1)'(cursor_reg) + (CW+1)'(1)) < (CW+1)'(count_reg);

    assign raddr = cmd.shift_rd ? slot_of(head_reg, cursor_inc) : slot_of(head_reg, rem_k);
    assign we    = cmd.shift_wr || (cmd.check && (do_push_f || do_push_b));
    assign wdata = cmd.shift_wr ? rdata_reg : req_reg.value_in;

    always_comb
    begin
        if (cmd.shift_wr)
            waddr = slot_of(head_reg, cursor_reg);
        else if (do_push_f)
            waddr = head_dec;
        else
            waddr = slot_of(head_reg, count_reg);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= request;
        if (cmd.check)
        begin
            status_reg <= chk_status;
            value_reg  <= '0;
            cursor_reg <= rem_k;
        end
        else if (cmd.shift_wr)
        begin
            cursor_reg <= cursor_inc;
        end
        if (cmd.capture)
            value_reg <= rdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            del_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.check)
            begin
                del_reg <= do_del;
                if (do_push_f)
                    head_reg <= head_dec;
                else if (do_pop_f)
                    head_reg <= head_inc;
                if (do_push_f || do_push_b)
                    count_reg <= count_reg + CW'(1);
                else if (do_pop_f || do_pop_b)
                    count_reg <= count_reg - CW'(1);
            end
            else if (cmd.finish)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    assign result.value_out     = value_reg;
    assign result.status        = status_reg;
    assign result.element_count = COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.check && (chk_status == ST_FULL))
            |=> (count_reg == $past(count_reg)) && (head_reg == $past(head_reg)))
        else $error("full push changed state");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> (cursor_reg < count_reg))
        else $error("shift beyond occupied range");

endmodule

`default_nettype wire

// ===== rtl/core/bounded_deque_with_positional_delete_top.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_delete_top
// Bounded deque of signed words with front/back push/pop and positional delete.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start; a transaction is taken at a rising edge
//   where start is high and busy is low. Every transaction gives exactly one
//   result on the result port, marked by done for a single cycle; the
//   receiver must take it then, as it cannot stall the block.
// Steps from the accepting edge to the result:
//   push, rejected request, unused op: decode, response
//   pop front / pop back:              decode, capture, response
//   delete before / after:             decode, capture, shift loop, response
//   (one store read and one store write per shifted element, single port
//   each way). A new transaction may be accepted in the cycle done is high,
//   but not while busy is high.
// Reset: rst_n clears head and count, the list is empty and busy is low.
//   Store contents are not cleared; only written entries are ever returned or moved.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_positional_delete_top
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t request,
    output logic      done,
    output rsp_t      result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

`default_nettype wire
